// ===== rtl/gtp_pkg.sv =====
// ----------------------------------------------------------------------------
// gtp_pkg: shared types and constants for the GTP header parser
// Holds the extension walk phase type, flag masks and field limits.
// ----------------------------------------------------------------------------
package gtp_pkg;

    localparam int GTP_POSITION_BITS = 16;
    localparam int GTP_OFFSET_BITS   = 18;

    localparam logic [7:0]  GTP_GPDU_TYPE  = 8'd255;
    localparam logic [2:0]  GTP_VERSION_1  = 3'd1;
    localparam logic [2:0]  GTP_VERSION_2  = 3'd2;
    localparam logic [7:0]  GTP_TEID_FLAG  = 8'h08;
    localparam logic [7:0]  GTP_EXT_FLAG   = 8'h04;
    localparam logic [7:0]  GTP_SEQ_FLAG   = 8'h02;
    localparam logic [7:0]  GTP_NPDU_FLAG  = 8'h01;
    localparam logic [GTP_OFFSET_BITS-1:0] GTP_OFFSET_RESET = 18'd4;
    localparam logic [GTP_OFFSET_BITS-1:0] GTP_OFFSET_MAX   = 18'h3FFFF;

    // Extension header walk phase
    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TYPE = 4'b0010,
        PH_LEN  = 4'b0100,
        PH_DONE = 4'b1000
    } gtp_phase_t;

endpackage

// ===== rtl/gtp_if.sv =====
// ----------------------------------------------------------------------------
// gtp_if: stream channels of the GTP header parser
// Byte channel into the parser and result channel out of it.
// ----------------------------------------------------------------------------
interface gtp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;

    modport source (output valid, data_byte, first_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, first_byte, last_byte, output ready);
endinterface

interface gtp_result_if;
    logic        valid;
    logic        ready;
    logic        header_valid;
    logic [2:0]  gtp_version;
    logic [7:0]  flag_bits;
    logic [7:0]  message_type;
    logic [15:0] message_length;
    logic [31:0] tunnel_id;
    logic [17:0] header_end;
    logic        payload_found;
    logic [15:0] payload_offset;
    logic [15:0] payload_length;

    modport source (
        output valid, header_valid, gtp_version, flag_bits, message_type,
               message_length, tunnel_id, header_end, payload_found,
               payload_offset, payload_length,
        input  ready
    );
    modport sink (
        input  valid, header_valid, gtp_version, flag_bits, message_type,
               message_length, tunnel_id, header_end, payload_found,
               payload_offset, payload_length,
        output ready
    );
endinterface

// ===== rtl/gtp_header_parser.sv =====
// ----------------------------------------------------------------------------
// gtp_header_parser: GTP tunnel header parser, one byte per transfer
// Parses version, flags, type, length, TEID and the extension header chain.
// ----------------------------------------------------------------------------
// Usage:
//   frame  : one byte per transfer, first_byte restarts parsing, last_byte
//            closes the frame and produces exactly one result transfer.
//   result : header fields, final header offset and, for a version 1 G-PDU
//            whose payload fits in the frame, payload offset and length.
// Throughput: one byte per cycle while frame.ready is high. Header state is
//   updated in the cycle a byte transfers; non-last bytes produce no result.
// Pipeline: the last byte's parse state is snapshotted in one register stage,
//   and the payload fit checks (one add, three compares) run into the result
//   register.
// Reset: rst_n clears position, fields, walk phase and offset (offset = 4)
//   and empties both stages. After every result the parse state returns to
//   its reset values, so a byte without first_byte starts a new header.
// Stall: when result.ready is low the result register holds; the snapshot
//   stage absorbs one more last byte, and frame.ready drops only when both
//   hold a result. Bytes past 2^POSITION_BITS - 1 are counted no further.
// ----------------------------------------------------------------------------
module gtp_header_parser
    import gtp_pkg::*;
#(
    parameter int POSITION_BITS = GTP_POSITION_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    gtp_byte_if.sink     frame,
    gtp_result_if.source result
);

    localparam int OB    = GTP_OFFSET_BITS;
    localparam int CMP_W = ((POSITION_BITS > OB) ? POSITION_BITS : OB) + 1;
    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

    // ---------------- parse state ----------------
    logic [POSITION_BITS-1:0] pos_reg,  pos_next;
    logic [7:0]               fhb_reg,  fhb_next;
    logic [7:0]               type_reg, type_next;
    logic [15:0]              len_reg,  len_next;
    logic [31:0]              teid_reg, teid_next;
    logic [OB-1:0]            ro_reg,   ro_next;
    gtp_phase_t               ph_reg,   ph_next;

    // working values after the first-byte restart
    logic [POSITION_BITS-1:0] pos_b;
    logic [7:0]               fhb_b, type_b;
    logic [15:0]              len_b;
    logic [31:0]              teid_b;
    logic [OB-1:0]            ro_b;
    gtp_phase_t               ph_b;

    logic [2:0]               ver_b;
    logic                     teid_b_present;
    logic [19:0]              walk_sum;
    logic                     at_offset;
    logic [7:0]               d;

    logic accept_in;
    logic snap_adv;

    // snapshot stage
    logic                     snap_valid_reg;
    logic [POSITION_BITS-1:0] snap_n_reg;
    logic [7:0]               snap_fhb_reg, snap_type_reg;
    logic [15:0]              snap_len_reg;
    logic [31:0]              snap_teid_reg;
    logic [OB-1:0]            snap_ro_reg;

    // result stage
    logic        out_valid_reg;
    logic        hv_reg, found_reg;
    logic [2:0]  ver_reg;
    logic [7:0]  flags_reg, mtype_reg;
    logic [15:0] mlen_reg, poff_reg, plen_reg;
    logic [31:0] tid_reg;
    logic [OB-1:0] hend_reg;

    assign snap_adv     = snap_valid_reg && (!out_valid_reg || result.ready);
    assign frame.ready  = !snap_valid_reg || !out_valid_reg || result.ready;
    assign accept_in    = frame.valid && frame.ready;
    assign d            = frame.data_byte;

    // ---------------- byte update ----------------
    always_comb
    begin
        if (frame.first_byte)
        begin
            pos_b  = '0;
            fhb_b  = '0;
            type_b = '0;
            len_b  = '0;
            teid_b = '0;
            ro_b   = GTP_OFFSET_RESET;
            ph_b   = PH_IDLE;
        end
        else
        begin
            pos_b  = pos_reg;
            fhb_b  = fhb_reg;
            type_b = type_reg;
            len_b  = len_reg;
            teid_b = teid_reg;
            ro_b   = ro_reg;
            ph_b   = ph_reg;
        end

        ver_b          = fhb_b[7:5];
        teid_b_present = (ver_b == GTP_VERSION_1) ||
                         ((ver_b == GTP_VERSION_2) && ((fhb_b & GTP_TEID_FLAG) != '0));
        at_offset      = (CMP_W'(pos_b) == CMP_W'(ro_b));
        walk_sum       = 20'(ro_b) + {10'd0, d, 2'b00} - 20'd1;

        pos_next  = pos_b;
        fhb_next  = fhb_b;
        type_next = type_b;
        len_next  = len_b;
        teid_next = teid_b;
        ro_next   = ro_b;
        ph_next   = ph_b;

        if (pos_b != POS_MAX)
        begin
            pos_next = pos_b + POSITION_BITS'(1);
            priority if (pos_b == POSITION_BITS'(0))
                fhb_next = d;
            else if (pos_b == POSITION_BITS'(1))
                type_next = d;
            else if (pos_b == POSITION_BITS'(2))
                len_next = {d, 8'h00};
            else if (pos_b == POSITION_BITS'(3))
                len_next = len_b | {8'h00, d};
            else if (pos_b < POSITION_BITS'(8))
            begin
                teid_next = {teid_b[23:0], d};
                if (pos_b == POSITION_BITS'(7))
                begin
                    // fixed header done: pick the walk start
                    ph_next = PH_DONE;
                    if ((ver_b == GTP_VERSION_1) && ((fhb_b & GTP_EXT_FLAG) != '0))
                    begin
                        ro_next = teid_b_present ? OB'(11) : OB'(7);
                        ph_next = PH_TYPE;
                    end
                    else if ((ver_b == GTP_VERSION_1) &&
                             ((fhb_b & (GTP_SEQ_FLAG | GTP_NPDU_FLAG)) != '0))
                        ro_next = teid_b_present ? OB'(12) : OB'(8);
                    else
                        ro_next = teid_b_present ? OB'(8) : OB'(4);
                end
            end
            else
            begin
                // extension walk: act only on the byte at the running offset
                if (at_offset && (ph_b == PH_TYPE))
                begin
                    ro_next = ro_b + OB'(1);
                    ph_next = (d == 8'd0) ? PH_DONE : PH_LEN;
                end
                else if (at_offset && (ph_b == PH_LEN))
                begin
                    if (d == 8'd0)
                        ph_next = PH_DONE;
                    else if (walk_sum > 20'(GTP_OFFSET_MAX))
                    begin
                        ro_next = GTP_OFFSET_MAX;
                        ph_next = PH_DONE;
                    end
                    else
                    begin
                        ro_next = walk_sum[OB-1:0];
                        ph_next = PH_TYPE;
                    end
                end
            end
        end
    end

    // ---------------- parse state registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg  <= '0;
            fhb_reg  <= '0;
            type_reg <= '0;
            len_reg  <= '0;
            teid_reg <= '0;
            ro_reg   <= GTP_OFFSET_RESET;
            ph_reg   <= PH_IDLE;
        end
        else if (accept_in)
        begin
            if (frame.last_byte)
            begin
                // drop all state once the last byte of the frame is taken
                pos_reg  <= '0;
                fhb_reg  <= '0;
                type_reg <= '0;
                len_reg  <= '0;
                teid_reg <= '0;
                ro_reg   <= GTP_OFFSET_RESET;
                ph_reg   <= PH_IDLE;
            end
            else
            begin
                pos_reg  <= pos_next;
                fhb_reg  <= fhb_next;
                type_reg <= type_next;
                len_reg  <= len_next;
                teid_reg <= teid_next;
                ro_reg   <= ro_next;
                ph_reg   <= ph_next;
            end
        end
    end

    // ---------------- snapshot stage ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            snap_valid_reg <= 1'b0;
        else if (accept_in && frame.last_byte)
            snap_valid_reg <= 1'b1;
        else if (snap_adv)
            snap_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept_in && frame.last_byte)
        begin
            snap_n_reg    <= pos_next;
            snap_fhb_reg  <= fhb_next;
            snap_type_reg <= type_next;
            snap_len_reg  <= len_next;
            snap_teid_reg <= teid_next;
            snap_ro_reg   <= ro_next;
        end
    end

    // ---------------- result computation ----------------
    logic        s_long, s_teid, s_gpdu, s_fits;
    logic [2:0]  s_ver;
    logic [16:0] s_total;

    always_comb
    begin
        s_ver   = snap_fhb_reg[7:5];
        s_long  = (snap_n_reg >= POSITION_BITS'(8));
        s_teid  = (s_ver == GTP_VERSION_1) ||
                  ((s_ver == GTP_VERSION_2) && ((snap_fhb_reg & GTP_TEID_FLAG) != '0));
        s_gpdu  = (s_ver == GTP_VERSION_1) && (snap_type_reg == GTP_GPDU_TYPE);
        s_total = 17'(snap_len_reg) + 17'd8;
        s_fits  = (CMP_W'(s_total) > CMP_W'(snap_ro_reg)) &&
                  (CMP_W'(s_total) <= CMP_W'(snap_n_reg)) &&
                  (snap_ro_reg <= OB'(16'hFFFF));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (snap_adv)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (snap_adv)
        begin
            hv_reg    <= s_long;
            ver_reg   <= s_long ? s_ver : 3'd0;
            flags_reg <= s_long ? snap_fhb_reg : 8'd0;
            mtype_reg <= s_long ? snap_type_reg : 8'd0;
            mlen_reg  <= s_long ? snap_len_reg : 16'd0;
            tid_reg   <= (s_long && s_teid) ? snap_teid_reg : 32'd0;
            hend_reg  <= s_long ? snap_ro_reg : '0;
            found_reg <= s_long && s_gpdu && s_fits;
            poff_reg  <= (s_long && s_gpdu && s_fits) ? snap_ro_reg[15:0] : 16'd0;
            plen_reg  <= (s_long && s_gpdu && s_fits) ?
                         16'(s_total - 17'(snap_ro_reg[15:0])) : 16'd0;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.header_valid   = hv_reg;
    assign result.gtp_version    = ver_reg;
    assign result.flag_bits      = flags_reg;
    assign result.message_type   = mtype_reg;
    assign result.message_length = mlen_reg;
    assign result.tunnel_id      = tid_reg;
    assign result.header_end     = hend_reg;
    assign result.payload_found  = found_reg;
    assign result.payload_offset = poff_reg;
    assign result.payload_length = plen_reg;

    // ---------------- assertions ----------------
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && frame.last_byte |=> (pos_reg == '0) && (ro_reg == GTP_OFFSET_RESET))
        else $error("parse state not cleared after last byte");

    a_offset_floor: assert property (@(posedge clk) disable iff (!rst_n)
        ro_reg >= GTP_OFFSET_RESET)
        else $error("running offset below fixed header size");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        !frame.ready |-> snap_valid_reg && out_valid_reg && !result.ready)
        else $error("byte channel stalled with room in the pipeline");

    a_found_gpdu: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && found_reg |-> hv_reg && (ver_reg == GTP_VERSION_1) &&
                                       (mtype_reg == GTP_GPDU_TYPE))
        else $error("payload reported for non G-PDU header");

    a_snap_moves: assert property (@(posedge clk) disable iff (!rst_n)
        snap_adv |=> out_valid_reg && (hv_reg == $past(s_long)))
        else $error("snapshot lost on its way to the result register");

endmodule
